[sv/evsm_pkg.sv]
`timescale 1ns / 1ps

package evsm_pkg;

    localparam int VOICE_COUNT_DEF      = 8;
    localparam int SAMPLE_ADDR_BITS_DEF = 16;

    localparam int POS_W    = 18;
    localparam int FRAC_W   = 16;
    localparam int STEP_W   = 19;
    localparam int GAIN_W   = 7;
    localparam int HANDLE_W = 16;
    localparam int TICK_W   = 31;
    localparam int ACC_W    = 21;

    localparam logic [HANDLE_W-1:0] HANDLE_FIRST = 16'd100;
    localparam logic [GAIN_W-1:0]   GAIN_MAX     = 7'd127;
    localparam logic signed [ACC_W-1:0] SAT_HI   = 21'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_LO   = -21'sd32767;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_MIX   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_START_SCAN,
        ST_START_COMMIT,
        ST_STOP,
        ST_MIX_SCAN,
        ST_MIX_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic mem_write;
        logic scan_step;
        logic start_commit;
        logic stop;
        logic mix_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
    } ctrl_stat_t;

    // 3.16 step from the pitch index
    function automatic logic [STEP_W-1:0] pitch_step(input logic [7:0] p);
        logic [STEP_W-1:0] base;
        base = {2'b00, 1'b1, p[5:0], 10'b0};
        if (p[7])
            pitch_step = base << p[6];
        else if (!p[6])
            pitch_step = base >> 2;
        else
            pitch_step = base >> 1;
    endfunction

endpackage

[sv/evsm_ctrl.sv]
`timescale 1ns / 1ps

module evsm_ctrl #(
    parameter int VOICE_COUNT = evsm_pkg::VOICE_COUNT_DEF,
    parameter int VIDX_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  evsm_pkg::ctrl_stat_t  stat,
    output evsm_pkg::ctrl_cmd_t   ctl,
    output logic [VIDX_W-1:0]     idx
);

    evsm_pkg::state_t  state_reg, state_next;
    logic [VIDX_W-1:0] idx_reg, idx_next;
    logic              m_valid_reg, m_valid_next;
    logic              last;

    assign last    = (idx_reg == VIDX_W'(VOICE_COUNT - 1));
    assign idx     = idx_reg;
    assign m_valid = m_valid_reg;
    assign s_ready = (state_reg == evsm_pkg::ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= evsm_pkg::ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ctl        = '0;
        case (state_reg)
            evsm_pkg::ST_IDLE: begin
                idx_next = '0;
                if (s_valid) begin
                    ctl.capture = 1'b1;
                    state_next  = evsm_pkg::ST_FINISH;
                end
            end
            evsm_pkg::ST_WRITE: begin
                ctl.mem_write = 1'b1;
                state_next    = evsm_pkg::ST_FINISH;
            end
            evsm_pkg::ST_START_SCAN: begin
                ctl.scan_step = 1'b1;
                idx_next      = idx_reg + 1'b1;
                if (last) begin
                    state_next = evsm_pkg::ST_START_COMMIT;
                end
            end
            evsm_pkg::ST_START_COMMIT: begin
                ctl.start_commit = 1'b1;
                state_next       = evsm_pkg::ST_FINISH;
            end
            evsm_pkg::ST_STOP: begin
                ctl.stop   = 1'b1;
                state_next = evsm_pkg::ST_FINISH;
            end
            evsm_pkg::ST_MIX_SCAN: begin
                ctl.mix_step = 1'b1;
                idx_next     = idx_reg + 1'b1;
                if (last) begin
                    state_next = evsm_pkg::ST_MIX_DRAIN;
                end
            end
            evsm_pkg::ST_MIX_DRAIN: begin
                state_next = evsm_pkg::ST_FINISH;
            end
            evsm_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    ctl.load_out = 1'b1;
                    state_next   = evsm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = evsm_pkg::ST_IDLE;
            end
        endcase
        // dispatch on the item just captured
        if (state_reg == evsm_pkg::ST_IDLE && s_valid) begin
            case (stat.cmd)
                evsm_pkg::CMD_WRITE: state_next = evsm_pkg::ST_WRITE;
                evsm_pkg::CMD_START: state_next = evsm_pkg::ST_START_SCAN;
                evsm_pkg::CMD_STOP:  state_next = evsm_pkg::ST_STOP;
                evsm_pkg::CMD_MIX:   state_next = evsm_pkg::ST_MIX_SCAN;
                default:             state_next = evsm_pkg::ST_FINISH;
            endcase
        end
        if (ctl.load_out)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

endmodule

[sv/evsm_datapath.sv]
`timescale 1ns / 1ps

module evsm_datapath #(
    parameter int VOICE_COUNT      = evsm_pkg::VOICE_COUNT_DEF,
    parameter int SAMPLE_ADDR_BITS = evsm_pkg::SAMPLE_ADDR_BITS_DEF,
    parameter int VIDX_W           = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  evsm_pkg::ctrl_cmd_t             ctl,
    input  logic [VIDX_W-1:0]               idx,
    output evsm_pkg::ctrl_stat_t            stat,
    input  logic [1:0]                      s_cmd,
    input  logic [15:0]                     s_mem_address,
    input  logic [7:0]                      s_mem_byte,
    input  logic [16:0]                     s_sound_length,
    input  logic [6:0]                      s_volume,
    input  logic [7:0]                      s_separation,
    input  logic [7:0]                      s_pitch,
    input  logic [30:0]                     s_game_tick,
    input  logic [15:0]                     s_handle_in,
    output logic signed [15:0]              m_left_sample,
    output logic signed [15:0]              m_right_sample,
    output logic [15:0]                     m_handle_out,
    output logic                            m_handle_playing
);

    localparam int POS_W  = evsm_pkg::POS_W;
    localparam int FRAC_W = evsm_pkg::FRAC_W;
    localparam int STEP_W = evsm_pkg::STEP_W;
    localparam int GAIN_W = evsm_pkg::GAIN_W;
    localparam int HW     = evsm_pkg::HANDLE_W;
    localparam int TW     = evsm_pkg::TICK_W;
    localparam int ACC_W  = evsm_pkg::ACC_W;
    localparam int MEM_DEPTH = 1 << SAMPLE_ADDR_BITS;

    // captured item
    logic [15:0]      addr_reg;
    logic [7:0]       byte_reg;
    logic [16:0]      len_reg;
    logic [6:0]       vol_reg;
    logic [7:0]       sep_reg;
    logic [7:0]       pitch_reg;
    logic [TW-1:0]    tick_reg;
    logic [HW-1:0]    hin_reg;

    // voice state
    logic              act_reg   [VOICE_COUNT];
    logic [POS_W-1:0]  pos_reg   [VOICE_COUNT];
    logic [POS_W-1:0]  end_reg   [VOICE_COUNT];
    logic [FRAC_W-1:0] frac_reg  [VOICE_COUNT];
    logic [STEP_W-1:0] step_reg  [VOICE_COUNT];
    logic [GAIN_W-1:0] gl_reg    [VOICE_COUNT];
    logic [GAIN_W-1:0] gr_reg    [VOICE_COUNT];
    logic [HW-1:0]     hdl_reg   [VOICE_COUNT];
    logic [TW-1:0]     stick_reg [VOICE_COUNT];
    logic [HW-1:0]     nhandle_reg;

    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] rd_reg;

    // slot search
    logic              found_reg;
    logic [VIDX_W-1:0] slot_reg;
    logic [TW-1:0]     oldest_reg;

    // pan squares
    logic [16:0] sql_reg, sqr_reg;
    logic [8:0]  pan_s, pan_t;

    // mix pipeline
    logic              pv_reg;
    logic [GAIN_W-1:0] pgl_reg, pgr_reg;
    logic signed [ACC_W-1:0] accl_reg, accr_reg;

    logic signed [15:0] ol_reg, or_reg;
    logic [HW-1:0]      ohout_reg, hout_reg;
    logic               oplay_reg;

    logic [HW-1:0]       h_new;
    logic [8:0]          vol4;
    logic [25:0]         prodl, prodr;
    logic [9:0]          gl_raw, gr_raw;
    logic [GAIN_W-1:0]   gl_new, gr_new;
    logic [FRAC_W+4-1:0] fsum;
    logic [POS_W-1:0]    pos_new;
    logic signed [8:0]   smp;
    logic                playing;

    assign stat.cmd = evsm_pkg::cmd_t'(s_cmd);

    assign pan_s = {1'b0, sep_reg} + 9'd1;
    assign pan_t = 9'd256 - {1'b0, sep_reg};

    assign h_new  = (nhandle_reg == '0) ? evsm_pkg::HANDLE_FIRST : nhandle_reg;
    assign vol4   = {vol_reg, 2'b00};
    assign prodl  = vol4 * sql_reg;
    assign prodr  = vol4 * sqr_reg;
    assign gl_raw = {1'b0, vol4} - prodl[25:16];
    assign gr_raw = {1'b0, vol4} - prodr[25:16];
    assign gl_new = (gl_raw > 10'd127) ? evsm_pkg::GAIN_MAX : gl_raw[GAIN_W-1:0];
    assign gr_new = (gr_raw > 10'd127) ? evsm_pkg::GAIN_MAX : gr_raw[GAIN_W-1:0];

    assign fsum    = (FRAC_W + 4)'(frac_reg[idx]) + (FRAC_W + 4)'(step_reg[idx]);
    assign pos_new = pos_reg[idx] + POS_W'(fsum[FRAC_W+3:FRAC_W]);
    assign smp     = $signed({1'b0, rd_reg}) - 9'sd128;

    always_comb begin
        playing = 1'b0;
        for (int j = 0; j < VOICE_COUNT; j++) begin
            if (act_reg[j] && hdl_reg[j] == hin_reg)
                playing = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mem_write)
            mem[SAMPLE_ADDR_BITS'(addr_reg)] <= byte_reg;
        rd_reg <= mem[SAMPLE_ADDR_BITS'(pos_reg[idx])];
    end

    always_ff @(posedge aclk) begin
        sql_reg <= pan_s * pan_s;
        sqr_reg <= pan_t * pan_t;
        if (ctl.capture) begin
            addr_reg  <= s_mem_address;
            byte_reg  <= s_mem_byte;
            len_reg   <= s_sound_length;
            vol_reg   <= s_volume;
            sep_reg   <= s_separation;
            pitch_reg <= s_pitch;
            tick_reg  <= s_game_tick;
            hin_reg   <= s_handle_in;
        end
    end

    // slot search: stop at the first idle voice, else track the oldest
    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            found_reg  <= 1'b0;
            slot_reg   <= '0;
            oldest_reg <= s_game_tick;
        end else if (ctl.scan_step && !found_reg) begin
            if (!act_reg[idx]) begin
                found_reg <= 1'b1;
                slot_reg  <= idx;
            end else if (stick_reg[idx] < oldest_reg) begin
                oldest_reg <= stick_reg[idx];
                slot_reg   <= idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < VOICE_COUNT; j++)
                act_reg[j] <= 1'b0;
            nhandle_reg <= '0;
            pv_reg      <= 1'b0;
        end else begin
            pv_reg <= ctl.mix_step && act_reg[idx];
            if (ctl.start_commit) begin
                act_reg[slot_reg] <= 1'b1;
                nhandle_reg       <= h_new + 1'b1;
            end
            if (ctl.stop) begin
                for (int j = 0; j < VOICE_COUNT; j++)
                    if (hdl_reg[j] == hin_reg)
                        act_reg[j] <= 1'b0;
            end
            if (ctl.mix_step && act_reg[idx] && pos_new >= end_reg[idx])
                act_reg[idx] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start_commit) begin
            pos_reg[slot_reg]   <= POS_W'(addr_reg);
            end_reg[slot_reg]   <= POS_W'(addr_reg) + POS_W'(len_reg);
            frac_reg[slot_reg]  <= '0;
            step_reg[slot_reg]  <= evsm_pkg::pitch_step(pitch_reg);
            hdl_reg[slot_reg]   <= h_new;
            stick_reg[slot_reg] <= tick_reg;
            gl_reg[slot_reg]    <= gl_new;
            gr_reg[slot_reg]    <= gr_new;
        end
        if (ctl.mix_step && act_reg[idx]) begin
            pos_reg[idx]  <= pos_new;
            frac_reg[idx] <= fsum[FRAC_W-1:0];
        end
        pgl_reg <= gl_reg[idx];
        pgr_reg <= gr_reg[idx];
    end

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            accl_reg <= '0;
            accr_reg <= '0;
            hout_reg <= '0;
        end else begin
            if (pv_reg) begin
                accl_reg <= accl_reg + ACC_W'(smp * $signed({1'b0, pgl_reg}));
                accr_reg <= accr_reg + ACC_W'(smp * $signed({1'b0, pgr_reg}));
            end
            if (ctl.start_commit)
                hout_reg <= h_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            if (accl_reg > evsm_pkg::SAT_HI)
                ol_reg <= 16'sd32767;
            else if (accl_reg < evsm_pkg::SAT_LO)
                ol_reg <= -16'sd32767;
            else
                ol_reg <= accl_reg[15:0];
            if (accr_reg > evsm_pkg::SAT_HI)
                or_reg <= 16'sd32767;
            else if (accr_reg < evsm_pkg::SAT_LO)
                or_reg <= -16'sd32767;
            else
                or_reg <= accr_reg[15:0];
            ohout_reg <= hout_reg;
            oplay_reg <= playing;
        end
    end

    assign m_left_sample    = ol_reg;
    assign m_right_sample   = or_reg;
    assign m_handle_out     = ohout_reg;
    assign m_handle_playing = oplay_reg;

endmodule

[sv/eight_voice_sample_mixer_core.sv]
`timescale 1ns / 1ps

// eight-voice pcm sample mixer: each item is one command (write a sample byte, start a
// voice, stop a handle, mix one stereo tick) and gives exactly one result item. the
// controller takes one item at a time; a start or mix runs a voice scan that visits one
// voice per cycle through the single sample memory read port, a write or stop does not.
// the result sits in an output register, so the next item is accepted while it waits;
// only a second finished result stalls, until the first one has been taken.
// sample memory is not cleared: reading a byte that was never written gives garbage.
module eight_voice_sample_mixer_core #(
    parameter int VOICE_COUNT      = evsm_pkg::VOICE_COUNT_DEF,
    parameter int SAMPLE_ADDR_BITS = evsm_pkg::SAMPLE_ADDR_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic [15:0]        s_mem_address,
    input  logic [7:0]         s_mem_byte,
    input  logic [16:0]        s_sound_length,
    input  logic [6:0]         s_volume,
    input  logic [7:0]         s_separation,
    input  logic [7:0]         s_pitch,
    input  logic [30:0]        s_game_tick,
    input  logic [15:0]        s_handle_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_left_sample,
    output logic signed [15:0] m_right_sample,
    output logic [15:0]        m_handle_out,
    output logic               m_handle_playing
);

    // voice index width
    localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    evsm_pkg::ctrl_cmd_t  ctl;
    evsm_pkg::ctrl_stat_t stat;
    logic [VIDX_W-1:0]    idx;

    // sequencer: dispatch, voice scan counter, output handshake
    evsm_ctrl #(
        .VOICE_COUNT (VOICE_COUNT),
        .VIDX_W      (VIDX_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctl     (ctl),
        .idx     (idx)
    );

    // voice registers, sample memory, pan and step maths, mix accumulators
    evsm_datapath #(
        .VOICE_COUNT      (VOICE_COUNT),
        .SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS),
        .VIDX_W           (VIDX_W)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctl              (ctl),
        .idx              (idx),
        .stat             (stat),
        .s_cmd            (s_cmd),
        .s_mem_address    (s_mem_address),
        .s_mem_byte       (s_mem_byte),
        .s_sound_length   (s_sound_length),
        .s_volume         (s_volume),
        .s_separation     (s_separation),
        .s_pitch          (s_pitch),
        .s_game_tick      (s_game_tick),
        .s_handle_in      (s_handle_in),
        .m_left_sample    (m_left_sample),
        .m_right_sample   (m_right_sample),
        .m_handle_out     (m_handle_out),
        .m_handle_playing (m_handle_playing)
    );

endmodule

[test/eight_voice_sample_mixer_core_tb.sv]
`timescale 1ns / 1ps

module eight_voice_sample_mixer_core_tb;

    localparam int VOICES      = 8;
    localparam int ITEM_TARGET = 2000;
    localparam int QUIET_LIMIT = 4000;   // cycles with no item moving on either side
    localparam int DRAIN_WAIT  = 24;

    // one command item as it goes into the block
    typedef struct {
        evsm_pkg::cmd_t cmd;
        logic [15:0]    addr;
        logic [7:0]     smp_byte;
        logic [16:0]    len;
        logic [6:0]     vol;
        logic [7:0]     sep;
        logic [7:0]     pit;
        logic [30:0]    tick;
        logic [15:0]    hin;
    } mixer_cmd_t;

    // one result item
    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [15:0]        hout;
        logic               playing;
    } mixer_out_t;

    // directed stimulus row, with the result typed in where it is obvious
    typedef struct {
        mixer_cmd_t item;
        bit         typed;
        mixer_out_t want;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_cmd;
    logic [15:0]        s_mem_address;
    logic [7:0]         s_mem_byte;
    logic [16:0]        s_sound_length;
    logic [6:0]         s_volume;
    logic [7:0]         s_separation;
    logic [7:0]         s_pitch;
    logic [30:0]        s_game_tick;
    logic [15:0]        s_handle_in;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_left_sample;
    logic signed [15:0] m_right_sample;
    logic [15:0]        m_handle_out;
    logic               m_handle_playing;

    eight_voice_sample_mixer_core i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_mem_address    (s_mem_address),
        .s_mem_byte       (s_mem_byte),
        .s_sound_length   (s_sound_length),
        .s_volume         (s_volume),
        .s_separation     (s_separation),
        .s_pitch          (s_pitch),
        .s_game_tick      (s_game_tick),
        .s_handle_in      (s_handle_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_sample    (m_left_sample),
        .m_right_sample   (m_right_sample),
        .m_handle_out     (m_handle_out),
        .m_handle_playing (m_handle_playing)
    );

    // 50 MHz clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // shadow of the mixer state
    bit [7:0]    mem_shadow [0:65535];
    bit          mem_written [0:65535];
    bit          v_active [VOICES];
    logic [31:0] v_pos [VOICES];
    logic [31:0] v_stop [VOICES];
    logic [31:0] v_frac [VOICES];
    logic [31:0] v_step [VOICES];
    logic [31:0] v_lgain [VOICES];
    logic [31:0] v_rgain [VOICES];
    logic [15:0] v_handle [VOICES];
    logic [30:0] v_tick [VOICES];
    logic [15:0] handle_next;

    mixer_out_t  pending_results [$];
    int          mismatches;
    int          quiet_cycles;
    int          items_sent;
    bit          calm;          // long stretch with no idling on either side
    logic [30:0] tick_now;

    // 16.16 step: base 1.xxxx from the low six bits, octave from the top two
    function automatic logic [31:0] step_of_pitch(input logic [7:0] p);
        logic [31:0] base;
        base = 32'h10000 | {16'd0, p[5:0], 10'd0};
        if (p >= 8'd128)
            return base << ((p - 8'd128) >> 6);
        return base >> ((p < 8'd64) ? 2 : 1);
    endfunction

    // quadratic pan law, clamped to the gain range
    function automatic logic [31:0] pan_law(input logic [31:0] v, input logic [31:0] d);
        logic [31:0] g;
        g = v - ((v * d * d) >> 16);
        return (g > 32'd127) ? 32'd127 : g;
    endfunction

    function automatic logic signed [15:0] clip16(input int x);
        if (x < -32767)
            return -16'sd32767;
        if (x > 32767)
            return 16'sd32767;
        return x[15:0];
    endfunction

    // advances the shadow state by one command and gives its result
    function automatic mixer_out_t mixer_next(input mixer_cmd_t it);
        mixer_out_t  r;
        int          slot;
        int          oldest_idx;
        logic [30:0] oldest;
        logic [31:0] vv;
        logic [31:0] ss;
        logic [31:0] f;
        int          dl;
        int          dr;
        int          smp;
        r = '{default: '0};
        dl = 0;
        dr = 0;
        case (it.cmd)
            evsm_pkg::CMD_WRITE: begin
                mem_shadow[it.addr] = it.smp_byte;
                mem_written[it.addr] = 1'b1;
            end
            evsm_pkg::CMD_START: begin
                slot = -1;
                for (int i = 0; i < VOICES; i++)
                    if (slot < 0 && !v_active[i])
                        slot = i;
                if (slot < 0) begin
                    // all busy: steal the oldest voice started before this tick
                    oldest = it.tick;
                    oldest_idx = 0;
                    for (int i = 0; i < VOICES; i++)
                        if (v_tick[i] < oldest) begin
                            oldest = v_tick[i];
                            oldest_idx = i;
                        end
                    slot = oldest_idx;
                end
                if (handle_next == 16'd0)
                    handle_next = 16'd100;
                r.hout = handle_next;
                handle_next = handle_next + 16'd1;
                vv = it.vol * 4;
                ss = it.sep + 1;
                v_active[slot] = 1'b1;
                v_pos[slot] = it.addr;
                v_stop[slot] = it.addr + it.len;
                v_frac[slot] = 0;
                v_step[slot] = step_of_pitch(it.pit);
                v_handle[slot] = r.hout;
                v_tick[slot] = it.tick;
                v_lgain[slot] = pan_law(vv, ss);
                v_rgain[slot] = pan_law(vv, 257 - ss);
            end
            evsm_pkg::CMD_STOP: begin
                for (int i = 0; i < VOICES; i++)
                    if (v_active[i] && v_handle[i] == it.hin)
                        v_active[i] = 1'b0;
            end
            default: begin
                for (int i = 0; i < VOICES; i++) begin
                    if (v_active[i]) begin
                        smp = int'(mem_shadow[v_pos[i][15:0]]) - 128;
                        dl += smp * int'(v_lgain[i]);
                        dr += smp * int'(v_rgain[i]);
                        f = v_frac[i] + v_step[i];
                        v_pos[i] = v_pos[i] + (f >> 16);
                        v_frac[i] = f & 32'hFFFF;
                        if (v_pos[i] >= v_stop[i])
                            v_active[i] = 1'b0;
                    end
                end
                r.left = clip16(dl);
                r.right = clip16(dr);
            end
        endcase
        for (int i = 0; i < VOICES; i++)
            if (v_active[i] && v_handle[i] == it.hin)
                r.playing = 1'b1;
        return r;
    endfunction

    function automatic mixer_cmd_t mk(input evsm_pkg::cmd_t c, input logic [15:0] a,
                                      input logic [7:0] b, input logic [16:0] n,
                                      input logic [6:0] vol, input logic [7:0] sep,
                                      input logic [7:0] pit, input logic [30:0] tk,
                                      input logic [15:0] h);
        mixer_cmd_t it;
        it.cmd = c;
        it.addr = a;
        it.smp_byte = b;
        it.len = n;
        it.vol = vol;
        it.sep = sep;
        it.pit = pit;
        it.tick = tk;
        it.hin = h;
        return it;
    endfunction

    function automatic mixer_out_t res(input logic signed [15:0] l, input logic signed [15:0] r,
                                       input logic [15:0] h, input logic p);
        mixer_out_t o;
        o.left = l;
        o.right = r;
        o.hout = h;
        o.playing = p;
        return o;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    // hands one item over, with a random gap first, and files its expected result
    task automatic push_item(input mixer_cmd_t it, input bit typed, input mixer_out_t want);
        mixer_out_t predicted;
        int gap;
        gap = (!calm && $urandom_range(99) < 30) ? $urandom_range(6, 1) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= it.cmd;
        s_mem_address  <= it.addr;
        s_mem_byte     <= it.smp_byte;
        s_sound_length <= it.len;
        s_volume       <= it.vol;
        s_separation   <= it.sep;
        s_pitch        <= it.pit;
        s_game_tick    <= it.tick;
        s_handle_in    <= it.hin;
        do
            @(posedge aclk);
        while (!s_ready);
        predicted = mixer_next(it);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // before a mix, fill in any byte an active voice is about to read
    task automatic issue_item(input mixer_cmd_t it, input bit typed, input mixer_out_t want);
        logic [15:0] a;
        if (it.cmd == evsm_pkg::CMD_MIX) begin
            for (int i = 0; i < VOICES; i++) begin
                a = v_pos[i][15:0];
                if (v_active[i] && !mem_written[a])
                    push_item(mk(evsm_pkg::CMD_WRITE, a, 8'($urandom), 17'd1, 7'd0, 8'd0,
                                 8'd0, tick_now, 16'd0), 1'b0, want);
            end
        end
        push_item(it, typed, want);
    endtask

    // pick a handle worth testing: mostly a live or recent one
    function automatic logic [15:0] pick_handle();
        int k;
        k = $urandom_range(99);
        if (k < 55)
            return v_handle[$urandom_range(VOICES - 1)];
        if (k < 75)
            return handle_next - 16'($urandom_range(12, 1));
        return 16'($urandom);
    endfunction

    function automatic mixer_cmd_t random_item();
        mixer_cmd_t it;
        int k;
        it = mk(evsm_pkg::CMD_MIX, 16'($urandom), 8'($urandom), 17'd1, 7'($urandom),
                8'($urandom), 8'($urandom), 31'd0, pick_handle());
        // ticks mostly creep forward, sometimes jump anywhere
        if ($urandom_range(99) < 5)
            tick_now = 31'($urandom);
        else
            tick_now = tick_now + 31'($urandom_range(3));
        it.tick = tick_now;
        k = $urandom_range(99);
        if (k < 25) begin
            it.cmd = evsm_pkg::CMD_WRITE;
            if ($urandom_range(1) == 1)
                it.addr = 16'hFFE0 + 16'($urandom_range(63));
        end else if (k < 45) begin
            it.cmd = evsm_pkg::CMD_START;
            k = $urandom_range(99);
            if (k < 70)
                it.len = 17'($urandom_range(48, 1));
            else if (k < 95)
                it.len = 17'($urandom_range(65536, 1));
            else
                it.len = 17'd65536;
            if ($urandom_range(1) == 1)
                it.addr = 16'hFFE0 + 16'($urandom_range(63));
        end else if (k < 55) begin
            it.cmd = evsm_pkg::CMD_STOP;
        end else begin
            it.cmd = evsm_pkg::CMD_MIX;
        end
        return it;
    endfunction

    // result side: random back-pressure and checking against the oldest expectation
    always @(posedge aclk) begin
        mixer_out_t want;
        if (aresetn) begin
            m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result item", 1, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_left_sample !== want.left)
                        report_mismatch("left_sample", m_left_sample, want.left);
                    if (m_right_sample !== want.right)
                        report_mismatch("right_sample", m_right_sample, want.right);
                    if (m_handle_out !== want.hout)
                        report_mismatch("handle_out", m_handle_out, want.hout);
                    if (m_handle_playing !== want.playing)
                        report_mismatch("handle_playing", m_handle_playing, want.playing);
                end
            end
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t  rows [$];
        mixer_out_t none;
        none = res(16'sd0, 16'sd0, 16'd0, 1'b0);
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = evsm_pkg::CMD_WRITE;
        s_mem_address = '0;
        s_mem_byte = '0;
        s_sound_length = '0;
        s_volume = '0;
        s_separation = '0;
        s_pitch = '0;
        s_game_tick = '0;
        s_handle_in = '0;
        m_ready = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        items_sent = 0;
        calm = 1'b0;
        tick_now = 31'd100;
        handle_next = 16'd0;
        for (int i = 0; i < VOICES; i++) begin
            v_active[i] = 1'b0;
            v_pos[i] = 0;
            v_stop[i] = 0;
            v_frac[i] = 0;
            v_step[i] = 0;
            v_lgain[i] = 0;
            v_rgain[i] = 0;
            v_handle[i] = 0;
            v_tick[i] = 0;
        end

        // directed part: empty mixer, byte extremes, address wrap, zero and full
        // lengths, every pitch octave, pan extremes, voice stealing and handle zero
        rows.push_back('{mk(evsm_pkg::CMD_MIX, 16'h0000, 8'h00, 17'd1, 7'd0, 8'd0,
                            8'd0, 31'd0, 16'd0), 1'b1, none});
        rows.push_back('{mk(evsm_pkg::CMD_STOP, 16'h0000, 8'h00, 17'd1, 7'd0, 8'd0,
                            8'd0, 31'd0, 16'd0), 1'b1, none});
        rows.push_back('{mk(evsm_pkg::CMD_WRITE, 16'hFFFE, 8'h00, 17'd1, 7'd0, 8'd0,
                            8'd0, 31'd1, 16'd0), 1'b1, none});
        rows.push_back('{mk(evsm_pkg::CMD_WRITE, 16'hFFFF, 8'hFF, 17'd1, 7'd0, 8'd0,
                            8'd0, 31'd1, 16'd0), 1'b1, none});
        rows.push_back('{mk(evsm_pkg::CMD_WRITE, 16'h0000, 8'h80, 17'd1, 7'd0, 8'd0,
                            8'd0, 31'd1, 16'd0), 1'b1, none});
        rows.push_back('{mk(evsm_pkg::CMD_WRITE, 16'h0001, 8'h7F, 17'd1, 7'd0, 8'd0,
                            8'd0, 31'd1, 16'd0), 1'b1, none});
        // first handle after reset is 100, playing right away
        rows.push_back('{mk(evsm_pkg::CMD_START, 16'hFFFE, 8'h00, 17'd4, 7'd127, 8'd0,
                            8'd255, 31'd5, 16'd100), 1'b1,
                         res(16'sd0, 16'sd0, 16'd100, 1'b1)});
        rows.push_back('{mk(evsm_pkg::CMD_START, 16'h0000, 8'h00, 17'd0, 7'd127, 8'd255,
                            8'd0, 31'd6, 16'd101), 1'b0, none});
        rows.push_back('{mk(evsm_pkg::CMD_START, 16'hFFFF, 8'h00, 17'd65536, 7'd127,
                            8'd128, 8'd128, 31'd7, 16'd102), 1'b0, none});
        rows.push_back('{mk(evsm_pkg::CMD_START, 16'h0001, 8'h00, 17'd1, 7'd0, 8'd64,
                            8'd63, 31'd3, 16'd103), 1'b0, none});
        rows.push_back('{mk(evsm_pkg::CMD_START, 16'hFFFE, 8'h00, 17'd2, 7'd64, 8'd192,
                            8'd64, 31'd9, 16'd0), 1'b0, none});
        rows.push_back('{mk(evsm_pkg::CMD_START, 16'hFFFF, 8'h00, 17'd3, 7'd100, 8'd1,
                            8'd127, 31'd9, 16'd0), 1'b0, none});
        rows.push_back('{mk(evsm_pkg::CMD_START, 16'h0000, 8'h00, 17'd2, 7'd1, 8'd254,
                            8'd191, 31'd10, 16'd0), 1'b0, none});
        rows.push_back('{mk(evsm_pkg::CMD_START, 16'hFFFE, 8'h00, 17'd3, 7'd127, 8'd127,
                            8'd192, 31'd11, 16'd0), 1'b0, none});
        // all eight busy: the voice with the lowest start tick is taken over
        rows.push_back('{mk(evsm_pkg::CMD_START, 16'h0000, 8'h00, 17'd2, 7'd90, 8'd200,
                            8'd150, 31'h7FFFFFFF, 16'd103), 1'b0, none});
        rows.push_back('{mk(evsm_pkg::CMD_MIX, 16'h0000, 8'h00, 17'd1, 7'd0, 8'd0,
                            8'd0, 31'd12, 16'd102), 1'b0, none});
        rows.push_back('{mk(evsm_pkg::CMD_MIX, 16'h0000, 8'h00, 17'd1, 7'd0, 8'd0,
                            8'd0, 31'd12, 16'd100), 1'b0, none});
        rows.push_back('{mk(evsm_pkg::CMD_STOP, 16'h0000, 8'h00, 17'd1, 7'd0, 8'd0,
                            8'd0, 31'd12, 16'd102), 1'b0, none});
        rows.push_back('{mk(evsm_pkg::CMD_MIX, 16'h0000, 8'h00, 17'd1, 7'd0, 8'd0,
                            8'd0, 31'd13, 16'hFFFF), 1'b0, none});
        rows.push_back('{mk(evsm_pkg::CMD_STOP, 16'h0000, 8'h00, 17'd1, 7'd0, 8'd0,
                            8'd0, 31'd13, 16'hFFFF), 1'b0, none});
        rows.push_back('{mk(evsm_pkg::CMD_WRITE, 16'h8000, 8'h01, 17'd1, 7'd0, 8'd0,
                            8'd0, 31'd13, 16'd0), 1'b0, none});
        rows.push_back('{mk(evsm_pkg::CMD_MIX, 16'h0000, 8'h00, 17'd1, 7'd0, 8'd0,
                            8'd0, 31'd14, 16'd107), 1'b0, none});

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i])
            issue_item(rows[i].item, rows[i].typed, rows[i].want);

        // random part, with a stretch in the middle where neither side idles
        while (items_sent < ITEM_TARGET) begin
            calm = (items_sent >= 800 && items_sent < 1100);
            issue_item(random_item(), 1'b0, none);
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
